/* hdl/fpdc_pkg.sv */
// Package for the fan PID duty controller: field widths, reset values of
// the gain registers, status codes and shared types. No dependencies.
package fpdc_pkg;

	localparam int SPEED_W     = 16;
	localparam int DUTY_W      = 7;
	localparam int STATUS_W    = 2;
	localparam int GAIN_W      = 24;
	localparam int ERR_W       = SPEED_W + 1;
	localparam int DERR_W      = ERR_W + 1;
	localparam int SUM_W       = 32;
	localparam int CALC_DUTY_W = 8;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int GAIN_FRAC_BITS_DEF = 20;
	localparam int DUTY_MAX_DEF       = 100;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd41943;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd7340;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd524;

	typedef enum logic [STATUS_W-1:0] {
		FAN_STOPPED  = 2'd0,
		FAN_LOCKED   = 2'd1,
		FAN_CHANGING = 2'd2
	} fan_state_t;

	typedef enum logic [1:0] {
		REG_PROP  = 2'd0,
		REG_INTEG = 2'd1,
		REG_DERIV = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} gains_t;

endpackage

/* hdl/fpdc_regs.sv */
// Gain register file behind the APB-style configuration port.
// Depends on fpdc_pkg.
module fpdc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fpdc_pkg::PADDR_W-1:0] paddr,
	input  logic [fpdc_pkg::PDATA_W-1:0] pwdata,
	output logic [fpdc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output fpdc_pkg::gains_t             gains
);
	import fpdc_pkg::*;

	gains_t   gains_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign gains  = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop  <= PROP_GAIN_RST;
			gains_q.integ <= INTEG_GAIN_RST;
			gains_q.deriv <= DERIV_GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP:  gains_q.prop  <= pwdata[GAIN_W-1:0];
				REG_INTEG: gains_q.integ <= pwdata[GAIN_W-1:0];
				REG_DERIV: gains_q.deriv <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROP:  prdata = PDATA_W'(gains_q.prop);
			REG_INTEG: prdata = PDATA_W'(gains_q.integ);
			REG_DERIV: prdata = PDATA_W'(gains_q.deriv);
			default:   prdata = '0;
		endcase
	end

endmodule

/* hdl/fan_pid_duty_controller.sv */
// Top level of the fan PID duty controller: request pipeline, PID state,
// duty clamp and status. Depends on fpdc_pkg and fpdc_regs.
//
//  channel   dir   handshake              payload
//  s_*       in    s_tvalid / s_tready    speed_target, speed_measured, present_duty
//  m_*       out   m_tvalid / m_tready    duty_out, fan_state
//  apb       in    psel & penable         prop_gain, integ_gain, deriv_gain
//
// One request per cycle sustained while m_tready stays high; results leave stage 3.
// Stage 1 updates the integral and previous error, stage 2 holds the three
// products, stage 3 is the output register (sum, clamp, status).
// Reset clears the valid bits, the PID state and restores the gains.
// Each stage holds while its successor is full and stalled; bubbles fill up.
module fan_pid_duty_controller #(
	parameter int GAIN_FRAC_BITS = fpdc_pkg::GAIN_FRAC_BITS_DEF,
	parameter int DUTY_MAX       = fpdc_pkg::DUTY_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [39:0]                  s_tdata,  // speed_target, speed_measured, present_duty
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,  // duty_out, fan_state
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fpdc_pkg::PADDR_W-1:0] paddr,
	input  logic [fpdc_pkg::PDATA_W-1:0] pwdata,
	output logic [fpdc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import fpdc_pkg::*;

	localparam int GAIN_SW = GAIN_W + 1;
	localparam int PP_W    = ERR_W + GAIN_SW;
	localparam int IP_W    = SUM_W + GAIN_SW;
	localparam int DP_W    = DERR_W + GAIN_SW;
	localparam int ACC_W   = IP_W + 2;

	gains_t gains;

	fpdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	// handshake
	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3   = !vld_s3 || m_tready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign m_tvalid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// stage 1: input register
	logic [SPEED_W-1:0] tgt_s1, meas_s1;
	logic [DUTY_W-1:0]  pres_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			tgt_s1  <= s_tdata[15:0];
			meas_s1 <= s_tdata[31:16];
			pres_s1 <= s_tdata[38:32];
		end
	end

	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [ERR_W-1:0]  err;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [DERR_W-1:0] derr;
	logic                     stop_s1;
	logic                     adv_s1;

	assign adv_s1   = vld_s1 && rdy_s2;
	assign stop_s1  = (pres_s1 == '0) && (tgt_s1 == '0);
	assign err      = $signed({1'b0, tgt_s1}) - $signed({1'b0, meas_s1});
	assign sum_wide = (SUM_W + 1)'(error_sum_q) + (SUM_W + 1)'(err);
	assign derr     = DERR_W'(err) - DERR_W'(last_error_q);

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (adv_s1) begin
			if (stop_s1) begin
				error_sum_q  <= '0;
				last_error_q <= '0;
			end else begin
				error_sum_q  <= sum_sat;
				last_error_q <= err;
			end
		end
	end

	// stage 2: products
	logic signed [PP_W-1:0] pprod_s2;
	logic signed [IP_W-1:0] iprod_s2;
	logic signed [DP_W-1:0] dprod_s2;
	logic [DUTY_W-1:0]      pres_s2;
	logic                   stop_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pprod_s2 <= PP_W'(err) * PP_W'($signed({1'b0, gains.prop}));
			iprod_s2 <= IP_W'(sum_sat) * IP_W'($signed({1'b0, gains.integ}));
			dprod_s2 <= DP_W'(derr) * DP_W'($signed({1'b0, gains.deriv}));
			pres_s2  <= pres_s1;
			stop_s2  <= stop_s1;
		end
	end

	// stage 3: sum, clamp, status
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] quo;
	logic [CALC_DUTY_W-1:0]  duty_calc;
	logic [DUTY_W-1:0]       duty_nxt;
	fan_state_t              state_nxt;

	assign acc = ACC_W'(pprod_s2) + ACC_W'(iprod_s2) + ACC_W'(dprod_s2);
	assign quo = acc >>> GAIN_FRAC_BITS;

	always_comb begin
		if (acc <= 0)
			duty_calc = '0;
		else if (quo > ACC_W'(DUTY_MAX))
			duty_calc = CALC_DUTY_W'(DUTY_MAX);
		else
			duty_calc = quo[CALC_DUTY_W-1:0];

		if (stop_s2) begin
			duty_nxt  = '0;
			state_nxt = FAN_STOPPED;
		end else if (duty_calc == {1'b0, pres_s2}) begin
			duty_nxt  = pres_s2;
			state_nxt = FAN_LOCKED;
		end else begin
			duty_nxt  = duty_calc[DUTY_W-1:0];
			state_nxt = FAN_CHANGING;
		end
	end

	logic [DUTY_W-1:0] duty_s3;
	fan_state_t        state_s3;

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			duty_s3  <= duty_nxt;
			state_s3 <= state_nxt;
		end
	end

	assign m_tdata = {7'd0, state_s3, duty_s3};

	// checks
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && stop_s1) |=> (error_sum_q == '0 && last_error_q == '0))
		else $error("PID state not cleared after stop request");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && state_s3 == FAN_STOPPED) |-> (duty_s3 == '0))
		else $error("stopped result with nonzero duty");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && state_s3 == FAN_CHANGING && DUTY_MAX < 128)
			|-> ({1'b0, duty_s3} <= CALC_DUTY_W'(DUTY_MAX)))
		else $error("duty above limit");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !m_tready && vld_s2) |=> (vld_s3 && vld_s2))
		else $error("stalled stage dropped a request");

endmodule
